// ===== design/cprp_pkg.sv =====
// Shared types and constants for the corner-point rectangle placer.
// Used by cprp_overlap, cprp_engine and corner_point_rectangle_placer_core.
package cprp_pkg;

    localparam int DEF_MAX_BINS  = 16;
    localparam int DEF_MAX_BOXES = 64;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_PLACE = 1'b1;

    localparam logic [1:0] STAT_PLACED = 2'd0;
    localparam logic [1:0] STAT_NOFIT  = 2'd1;
    localparam logic [1:0] STAT_FULL   = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [15:0] w;
        logic [15:0] h;
        logic [15:0] cost;
    } item_t;

    typedef struct packed {
        logic [3:0]  idx;
        logic [15:0] x;
        logic [15:0] y;
        logic        rot;
        logic [1:0]  status;
    } res_t;

    typedef struct packed {
        logic fits;
        logic overlap;
    } chk_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LSCAN, ST_LINS, ST_BIN, ST_KRD, ST_KCHK, ST_FIT,
        ST_PRD, ST_PCHK, ST_MRD, ST_MWR, ST_APP1, ST_APP2, ST_OUT
    } state_t;

endpackage

// ===== design/cprp_overlap.sv =====
// Shared compare unit: container bounds check and rectangle overlap test.
// Depends on cprp_pkg.
module cprp_overlap (
    input  logic [15:0]    cx,
    input  logic [15:0]    cy,
    input  logic [15:0]    cw,
    input  logic [15:0]    ch,
    input  logic [15:0]    px,
    input  logic [15:0]    py,
    input  logic [15:0]    pw,
    input  logic [15:0]    ph,
    input  logic [15:0]    lim_w,
    input  logic [15:0]    lim_h,
    output cprp_pkg::chk_t chk
);
    import cprp_pkg::*;

    logic [16:0] cxe, cye, pxe, pye, xlo, xhi, ylo, yhi;

    always_comb begin
        cxe = {1'b0, cx} + {1'b0, cw};
        cye = {1'b0, cy} + {1'b0, ch};
        pxe = {1'b0, px} + {1'b0, pw};
        pye = {1'b0, py} + {1'b0, ph};
        xlo = (cx > px) ? {1'b0, cx} : {1'b0, px};
        xhi = (cxe < pxe) ? cxe : pxe;
        ylo = (cy > py) ? {1'b0, cy} : {1'b0, py};
        yhi = (cye < pye) ? cye : pye;
        chk.fits    = (cxe <= {1'b0, lim_w}) && (cye <= {1'b0, lim_h});
        chk.overlap = (xlo < xhi) && (ylo < yhi);
    end

endmodule

// ===== design/cprp_engine.sv =====
// Sequencer, container table and corner/box memories of the placer.
// Depends on cprp_pkg and cprp_overlap.
module cprp_engine #(
    parameter int MAX_BINS  = cprp_pkg::DEF_MAX_BINS,
    parameter int MAX_BOXES = cprp_pkg::DEF_MAX_BOXES
) (
    input  logic            clk,
    input  logic            rstn,
    input  logic            start,
    input  cprp_pkg::item_t item,
    output logic            ready,
    input  logic            out_free,
    output logic            res_valid,
    output cprp_pkg::res_t  res
);
    import cprp_pkg::*;

    localparam int CAP    = MAX_BINS + MAX_BOXES;
    localparam int BIN_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int BCNT_W = $clog2(MAX_BINS + 1);
    localparam int CCNT_W = $clog2(CAP + 1);
    localparam int CIDX_W = $clog2(CAP);
    localparam int PCNT_W = $clog2(MAX_BOXES + 1);
    localparam int PIDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CE_W   = BIN_W + 32;
    localparam int PE_W   = BIN_W + 64;

    state_t state_reg, state_next;

    logic [BCNT_W-1:0] bin_count_reg, bin_count_next;
    logic [CCNT_W-1:0] corner_count_reg, corner_count_next;
    logic [PCNT_W-1:0] placed_count_reg, placed_count_next;
    logic [MAX_BINS-1:0] bin_used_reg;
    logic [15:0] bin_w_reg [MAX_BINS];
    logic [15:0] bin_h_reg [MAX_BINS];
    logic [15:0] bin_cost_reg [MAX_BINS];
    logic [BIN_W-1:0] order_reg [MAX_BINS];

    logic [15:0] w_reg, w_next, h_reg, h_next, cost_reg, cost_next;
    logic [BCNT_W-1:0] r_reg, r_next, pos_reg, pos_next;
    logic pass_reg, pass_next, rot_reg, rot_next, found_reg, found_next;
    logic best_rot_reg, best_rot_next;
    logic [BIN_W-1:0] b_reg, b_next;
    logic [CCNT_W-1:0] k_reg, k_next, best_k_reg, best_k_next, j_reg, j_next;
    logic [PCNT_W-1:0] i_reg, i_next;
    logic [16:0] best_sum_reg, best_sum_next;
    logic [15:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [15:0] bx_reg, bx_next, by_reg, by_next;
    res_t res_reg, res_next;

    logic [CE_W-1:0] cmem [CAP];
    logic [CE_W-1:0] cq;
    logic [PE_W-1:0] pmem [MAX_BOXES];
    logic [PE_W-1:0] pq;

    logic              cw_en, pw_en, ins_en, used_set;
    logic [CIDX_W-1:0] cw_addr, cr_addr;
    logic [CE_W-1:0]   cw_data;
    logic [PIDX_W-1:0] pr_addr;

    logic load_full, box_full, r_end, k_end, i_end, m_end, bin_ok, cost_gt;
    logic better, room, ovl_hit;
    logic [BIN_W-1:0] cur_b;
    logic [15:0] ew, eh, bew, beh;
    logic [16:0] sum;
    logic [CCNT_W-1:0] jm1, ccm1;
    logic [BIN_W+3:0] b_wide;
    chk_t chk;

    always_comb begin
        cur_b     = order_reg[r_reg[BIN_W-1:0]];
        load_full = (bin_count_reg >= BCNT_W'(MAX_BINS)) ||
                    (corner_count_reg >= CCNT_W'(CAP));
        box_full  = placed_count_reg >= PCNT_W'(MAX_BOXES);
        r_end     = r_reg == bin_count_reg;
        k_end     = k_reg == corner_count_reg;
        i_end     = i_reg == placed_count_reg;
        m_end     = j_reg == corner_count_reg;
        bin_ok    = bin_used_reg[cur_b] == !pass_reg;
        cost_gt   = bin_cost_reg[cur_b] > cost_reg;
        ew        = rot_reg ? h_reg : w_reg;
        eh        = rot_reg ? w_reg : h_reg;
        bew       = best_rot_reg ? h_reg : w_reg;
        beh       = best_rot_reg ? w_reg : h_reg;
        sum       = {1'b0, cx_reg} + {1'b0, cy_reg};
        better    = !found_reg || (sum < best_sum_reg);
        room      = corner_count_reg < CCNT_W'(CAP);
        ovl_hit   = (pq[PE_W-1 -: BIN_W] == b_reg) && chk.overlap;
        jm1       = j_reg - 1'b1;
        ccm1      = corner_count_reg - 1'b1;
        b_wide    = {4'b0, b_reg};
    end

    cprp_overlap u_cmp (
        .cx    (cx_reg),
        .cy    (cy_reg),
        .cw    (ew),
        .ch    (eh),
        .px    (pq[63:48]),
        .py    (pq[47:32]),
        .pw    (pq[31:16]),
        .ph    (pq[15:0]),
        .lim_w (bin_w_reg[b_reg]),
        .lim_h (bin_h_reg[b_reg]),
        .chk   (chk)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    if (item.mode == MODE_LOAD) begin
                        state_next = load_full ? ST_IDLE : ST_LSCAN;
                    end else begin
                        state_next = box_full ? ST_OUT : ST_BIN;
                    end
                end
            end
            ST_LSCAN: begin
                if (r_end || cost_gt) state_next = ST_LINS;
            end
            ST_LINS: state_next = ST_IDLE;
            ST_BIN: begin
                if (r_end) begin
                    state_next = pass_reg ? ST_OUT : ST_BIN;
                end else if (bin_ok) begin
                    state_next = ST_KRD;
                end
            end
            ST_KRD: begin
                if (!k_end) state_next = ST_KCHK;
                else if (!found_reg) state_next = ST_BIN;
                else state_next = room ? ST_MRD : ST_OUT;
            end
            ST_KCHK: begin
                state_next = (cq[CE_W-1 -: BIN_W] == b_reg) ? ST_FIT : ST_KRD;
            end
            ST_FIT: begin
                if (chk.fits) state_next = ST_PRD;
                else state_next = rot_reg ? ST_KRD : ST_FIT;
            end
            ST_PRD: begin
                if (i_end) state_next = rot_reg ? ST_KRD : ST_FIT;
                else state_next = ST_PCHK;
            end
            ST_PCHK: begin
                if (ovl_hit) state_next = rot_reg ? ST_KRD : ST_FIT;
                else state_next = ST_PRD;
            end
            ST_MRD:  state_next = m_end ? ST_APP1 : ST_MWR;
            ST_MWR:  state_next = ST_MRD;
            ST_APP1: state_next = ST_APP2;
            ST_APP2: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        bin_count_next    = bin_count_reg;
        corner_count_next = corner_count_reg;
        placed_count_next = placed_count_reg;
        w_next = w_reg;  h_next = h_reg;  cost_next = cost_reg;
        r_next = r_reg;  pos_next = pos_reg;  pass_next = pass_reg;
        rot_next = rot_reg;  found_next = found_reg;  best_rot_next = best_rot_reg;
        b_next = b_reg;  k_next = k_reg;  best_k_next = best_k_reg;  j_next = j_reg;
        i_next = i_reg;  best_sum_next = best_sum_reg;
        cx_next = cx_reg;  cy_next = cy_reg;  bx_next = bx_reg;  by_next = by_reg;
        res_next  = res_reg;
        cw_en     = 1'b0;
        cw_addr   = corner_count_reg[CIDX_W-1:0];
        cw_data   = {b_reg, bx_reg, by_reg};
        cr_addr   = k_reg[CIDX_W-1:0];
        pr_addr   = i_reg[PIDX_W-1:0];
        pw_en     = 1'b0;
        ins_en    = 1'b0;
        used_set  = 1'b0;
        ready     = 1'b0;
        res_valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                ready = 1'b1;
                if (start) begin
                    w_next    = item.w;
                    h_next    = item.h;
                    cost_next = item.cost;
                    r_next    = '0;
                    pass_next = 1'b0;
                    res_next  = '{idx: 4'd0, x: 16'd0, y: 16'd0, rot: 1'b0,
                                  status: STAT_FULL};
                end
            end
            ST_LSCAN: begin
                if (r_end || cost_gt) pos_next = r_reg;
                else r_next = r_reg + 1'b1;
            end
            ST_LINS: begin
                ins_en            = 1'b1;
                cw_en             = 1'b1;
                cw_data           = {bin_count_reg[BIN_W-1:0], 32'd0};
                corner_count_next = corner_count_reg + 1'b1;
                bin_count_next    = bin_count_reg + 1'b1;
            end
            ST_BIN: begin
                if (r_end) begin
                    pass_next = 1'b1;
                    r_next    = '0;
                    res_next  = '{idx: 4'd0, x: 16'd0, y: 16'd0, rot: 1'b0,
                                  status: STAT_NOFIT};
                end else if (bin_ok) begin
                    b_next     = cur_b;
                    k_next     = '0;
                    found_next = 1'b0;
                end else begin
                    r_next = r_reg + 1'b1;
                end
            end
            ST_KRD: begin
                if (k_end) begin
                    if (!found_reg) r_next = r_reg + 1'b1;
                    else if (room) j_next = best_k_reg + 1'b1;
                    else res_next = '{idx: 4'd0, x: 16'd0, y: 16'd0, rot: 1'b0,
                                      status: STAT_NOFIT};
                end
            end
            ST_KCHK: begin
                if (cq[CE_W-1 -: BIN_W] == b_reg) begin
                    cx_next  = cq[31:16];
                    cy_next  = cq[15:0];
                    rot_next = 1'b0;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_FIT: begin
                if (chk.fits) i_next = '0;
                else if (rot_reg) k_next = k_reg + 1'b1;
                else rot_next = 1'b1;
            end
            ST_PRD: begin
                if (i_end) begin
                    if (better) begin
                        found_next    = 1'b1;
                        best_sum_next = sum;
                        best_k_next   = k_reg;
                        best_rot_next = rot_reg;
                        bx_next       = cx_reg;
                        by_next       = cy_reg;
                    end
                    if (rot_reg) k_next = k_reg + 1'b1;
                    else rot_next = 1'b1;
                end
            end
            ST_PCHK: begin
                if (ovl_hit) begin
                    if (rot_reg) k_next = k_reg + 1'b1;
                    else rot_next = 1'b1;
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_MRD: begin
                cr_addr = j_reg[CIDX_W-1:0];
            end
            ST_MWR: begin
                cw_en   = 1'b1;
                cw_addr = jm1[CIDX_W-1:0];
                cw_data = cq;
                j_next  = j_reg + 1'b1;
            end
            ST_APP1: begin
                cw_en   = 1'b1;
                cw_addr = ccm1[CIDX_W-1:0];
                cw_data = {b_reg, bx_reg, by_reg + beh};
            end
            ST_APP2: begin
                cw_en             = 1'b1;
                cw_data           = {b_reg, bx_reg + bew, by_reg};
                corner_count_next = corner_count_reg + 1'b1;
                pw_en             = 1'b1;
                placed_count_next = placed_count_reg + 1'b1;
                used_set          = 1'b1;
                res_next          = '{idx: b_wide[3:0], x: bx_reg, y: by_reg,
                                      rot: best_rot_reg, status: STAT_PLACED};
            end
            ST_OUT: begin
                res_valid = out_free;
            end
            default: ;
        endcase
    end

    assign res = res_reg;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg        <= ST_IDLE;
            bin_count_reg    <= '0;
            corner_count_reg <= '0;
            placed_count_reg <= '0;
            bin_used_reg     <= '0;
        end else begin
            state_reg        <= state_next;
            bin_count_reg    <= bin_count_next;
            corner_count_reg <= corner_count_next;
            placed_count_reg <= placed_count_next;
            if (ins_en) bin_used_reg[bin_count_reg[BIN_W-1:0]] <= 1'b0;
            if (used_set) bin_used_reg[b_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        w_reg <= w_next;  h_reg <= h_next;  cost_reg <= cost_next;
        r_reg <= r_next;  pos_reg <= pos_next;  pass_reg <= pass_next;
        rot_reg <= rot_next;  found_reg <= found_next;  best_rot_reg <= best_rot_next;
        b_reg <= b_next;  k_reg <= k_next;  best_k_reg <= best_k_next;  j_reg <= j_next;
        i_reg <= i_next;  best_sum_reg <= best_sum_next;
        cx_reg <= cx_next;  cy_reg <= cy_next;  bx_reg <= bx_next;  by_reg <= by_next;
        res_reg <= res_next;
        if (ins_en) begin
            bin_w_reg[bin_count_reg[BIN_W-1:0]]    <= w_reg;
            bin_h_reg[bin_count_reg[BIN_W-1:0]]    <= h_reg;
            bin_cost_reg[bin_count_reg[BIN_W-1:0]] <= cost_reg;
            for (int n = 1; n < MAX_BINS; n++) begin
                if (n > int'(pos_reg) && n <= int'(bin_count_reg)) begin
                    order_reg[n] <= order_reg[n-1];
                end
            end
            order_reg[pos_reg[BIN_W-1:0]] <= bin_count_reg[BIN_W-1:0];
        end
    end

    always_ff @(posedge clk) begin
        if (cw_en) cmem[cw_addr] <= cw_data;
        cq <= cmem[cr_addr];
    end

    always_ff @(posedge clk) begin
        if (pw_en) begin
            pmem[placed_count_reg[PIDX_W-1:0]] <= {b_reg, bx_reg, by_reg, bew, beh};
        end
        pq <= pmem[pr_addr];
    end

endmodule

// ===== design/corner_point_rectangle_placer_core.sv =====
// Top level of the corner-point rectangle placer: stream ports and result register.
// Depends on cprp_pkg and cprp_engine.
//
//   port group | dir | tdata                                   | tuser
//   s_*        | in  | width[15:0] height[31:16] cost[47:32]   | mode[0]
//   m_*        | out | index[3:0] x[19:4] y[35:20] rotated[36] | status[1:0]
//
// A load request scans the bins in cost order and then inserts the new bin. A place request walks
// passes x bins x corners x 2 rotations through the shared compare unit, reading and checking
// each stored box, and then shifts the corners above the one removed.
// Reset clears counts and used flags; the block takes no request while busy and
// holds a finished result in the output register until m_tready.
module corner_point_rectangle_placer_core #(
    parameter int MAX_BINS  = cprp_pkg::DEF_MAX_BINS,
    parameter int MAX_BOXES = cprp_pkg::DEF_MAX_BOXES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // item_width, item_height, item_cost
    input  logic [0:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // bin index, pos_x, pos_y, rotated, zero pad
    output logic [1:0]  m_tuser    // status
);
    import cprp_pkg::*;

    item_t item;
    res_t  eng_res, out_reg;
    logic  eng_ready, eng_valid, start, out_free, m_tvalid_reg;

    assign item     = '{mode: s_tuser[0], w: s_tdata[15:0], h: s_tdata[31:16],
                        cost: s_tdata[47:32]};
    assign s_tready = eng_ready;
    assign start    = s_tvalid && eng_ready;
    assign out_free = !m_tvalid_reg || m_tready;

    cprp_engine #(
        .MAX_BINS  (MAX_BINS),
        .MAX_BOXES (MAX_BOXES)
    ) u_engine (
        .clk       (aclk),
        .rstn      (aresetn),
        .start     (start),
        .item      (item),
        .ready     (eng_ready),
        .out_free  (out_free),
        .res_valid (eng_valid),
        .res       (eng_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (eng_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (eng_valid) out_reg <= eng_res;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_reg.rot, out_reg.y, out_reg.x, out_reg.idx};
    assign m_tuser  = out_reg.status;

endmodule
